@@ rtl/kst_pkg.sv @@
`timescale 1ns / 1ps

package kst_pkg;

    // Field widths
    localparam int CNT_W  = 20;
    localparam int KIND_W = 4;

    // Text size and saturation limits
    localparam longint TEXT_BYTES = 64'd1048576;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] OFFSET_MAX =
        ((TEXT_BYTES - 1) < longint'(CNT_MAX)) ? CNT_W'(TEXT_BYTES - 1) : CNT_MAX;

    // Output queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Token kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_END     = 4'd0,
        KIND_SYMBOL  = 4'd1,
        KIND_KEYWORD = 4'd2,
        KIND_INVALID = 4'd3,
        KIND_GREATER = 4'd4,
        KIND_LOWER   = 4'd5,
        KIND_DASH    = 4'd6,
        KIND_OPEN    = 4'd7,
        KIND_CLOSE   = 4'd8
    } t_kind;

    // One result item
    typedef struct packed {
        t_kind            kind;
        logic [CNT_W-1:0] offset;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] len;
        logic             last;
    } t_token;

    // Up to two results written into the queue in one cycle, a before b
    typedef struct packed {
        logic   a_valid;
        t_token a;
        logic   b_valid;
        t_token b;
    } t_push;

    // Keywords: case, run, trace
    localparam int KW_NUM = 3;
    localparam int KW_MAX = 5;
    localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAX] = '{
        '{8'h63, 8'h61, 8'h73, 8'h65, 8'h00},
        '{8'h72, 8'h75, 8'h6e, 8'h00, 8'h00},
        '{8'h74, 8'h72, 8'h61, 8'h63, 8'h65}
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd4, 3'd3, 3'd5};

    // Drop candidates that no longer match the byte at position len
    function automatic logic [KW_NUM-1:0] kw_match(logic [KW_NUM-1:0] cand,
                                                   logic [CNT_W-1:0] len,
                                                   logic [7:0] c);
        logic [KW_NUM-1:0] res;
        res = cand;
        for (int i = 0; i < KW_NUM; i++) begin
            if (len >= {{(CNT_W-3){1'b0}}, KW_LEN[i]}) begin
                res[i] = 1'b0;
            end else if (KW_TEXT[i][len[2:0]] != c) begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    // A surviving candidate of exactly the symbol's length is a keyword
    function automatic logic kw_hit(logic [KW_NUM-1:0] cand, logic [CNT_W-1:0] len);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < KW_NUM; i++) begin
            if (cand[i] && len == {{(CNT_W-3){1'b0}}, KW_LEN[i]}) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

@@ rtl/keyword_symbol_tokenizer.sv @@
`timescale 1ns / 1ps

// Streaming tokenizer: one source byte per input transaction, closed by an
// end transaction. Input and output are valid/ready; an accepted byte sits in
// an input register and is scanned once the queue has room for two results,
// its results (none, one or two) going into a four-entry output queue that
// drives the result ports. A new byte is taken every cycle while the queue
// has room for two results, so the sustained rate is one byte per cycle when
// the consumer keeps up; a byte that ends a symbol and is itself a token
// makes two results, which drain at one per cycle. Offsets, rows and lengths
// saturate at 2^20-1; the end token has length zero and returns all position
// state to zero.
module keyword_symbol_tokenizer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_ch,
    input  logic                     i_end_of_text,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [kst_pkg::KIND_W-1:0] o_token_kind,
    output logic [kst_pkg::CNT_W-1:0]  o_start_offset,
    output logic [kst_pkg::CNT_W-1:0]  o_start_row,
    output logic [kst_pkg::CNT_W-1:0]  o_start_col,
    output logic [kst_pkg::CNT_W-1:0]  o_token_len,
    output logic                     o_last
);
    import kst_pkg::*;

    t_push  push;
    t_token head;
    logic   room;

    kst_lexer u_lexer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_ch          (i_ch),
        .i_end_of_text (i_end_of_text),
        .i_room        (room),
        .o_push        (push)
    );

    kst_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_token (head),
        .o_valid (o_valid),
        .i_ready (i_ready)
    );

    assign o_token_kind   = head.kind;
    assign o_start_offset = head.offset;
    assign o_start_row    = head.row;
    assign o_start_col    = head.col;
    assign o_token_len    = head.len;
    assign o_last         = head.last;

endmodule

@@ rtl/kst_out_fifo.sv @@
`timescale 1ns / 1ps

module kst_out_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kst_pkg::t_push i_push,
    output logic           o_room,
    output kst_pkg::t_token o_token,
    output logic           o_valid,
    input  logic           i_ready
);
    import kst_pkg::*;

    t_token            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, n_wptr;
    logic [FIFO_AW-1:0] r_rptr, n_rptr;
    logic [FIFO_AW:0]   r_count, n_count;

    logic pop;
    logic [1:0] push_num;
    logic [FIFO_AW-1:0] wptr_b;

    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rptr];
    // Room for the worst case of two writes
    assign o_room  = (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign pop     = o_valid && i_ready;

    assign push_num = {1'b0, i_push.a_valid} + {1'b0, i_push.b_valid};
    assign wptr_b   = i_push.a_valid ? r_wptr + 1'b1 : r_wptr;

    // Pointer and count update
    always_comb begin
        n_wptr  = r_wptr + FIFO_AW'(push_num);
        n_rptr  = pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + (FIFO_AW+1)'(push_num) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wptr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_mem[wptr_b] <= i_push.b;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("output queue count beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.a_valid || i_push.b_valid) |-> o_room)
        else $error("write into output queue without room");

    a_two_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.a_valid && i_push.b_valid && !pop) |=>
            r_count == $past(r_count) + (FIFO_AW+1)'(2))
        else $error("double write not counted");
`endif

endmodule

@@ rtl/kst_lexer.sv @@
`timescale 1ns / 1ps

module kst_lexer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_ch,
    input  logic           i_end_of_text,
    input  logic           i_room,
    output kst_pkg::t_push o_push
);
    import kst_pkg::*;

    // Input register
    logic             r_in_valid;
    logic [7:0]       r_ch;
    logic             r_eot;

    // Scanner state
    logic              r_in_symbol, n_in_symbol;
    logic [CNT_W-1:0]  r_cursor, n_cursor;
    logic [CNT_W-1:0]  r_row, n_row;
    logic [CNT_W-1:0]  r_row_start, n_row_start;
    logic [CNT_W-1:0]  r_sym_off, n_sym_off;
    logic [CNT_W-1:0]  r_sym_row, n_sym_row;
    logic [CNT_W-1:0]  r_sym_len, n_sym_len;
    logic [KW_NUM-1:0] r_cand, n_cand;

    logic fire;
    logic is_alnum, is_space;
    logic [CNT_W-1:0] cur_inc;
    t_kind byte_kind;
    t_token sym_tok, cur_tok;

    assign fire    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || fire;

    // Byte classes
    always_comb begin
        is_alnum = r_ch inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
        is_space = r_ch inside {[8'h09:8'h0d], 8'h20};
        case (r_ch)
            8'h3e:   byte_kind = KIND_GREATER;
            8'h3c:   byte_kind = KIND_LOWER;
            8'h2d:   byte_kind = KIND_DASH;
            8'h7b:   byte_kind = KIND_OPEN;
            8'h7d:   byte_kind = KIND_CLOSE;
            default: byte_kind = KIND_INVALID;
        endcase
    end

    assign cur_inc = (r_cursor < OFFSET_MAX) ? r_cursor + 1'b1 : r_cursor;

    // Candidate tokens: pending symbol and the token at the cursor
    always_comb begin
        sym_tok.kind   = kw_hit(r_cand, r_sym_len) ? KIND_KEYWORD : KIND_SYMBOL;
        sym_tok.offset = r_sym_off;
        sym_tok.row    = r_sym_row;
        sym_tok.col    = r_sym_off - r_row_start;
        sym_tok.len    = r_sym_len;
        sym_tok.last   = 1'b0;

        cur_tok.kind   = r_eot ? KIND_END : byte_kind;
        cur_tok.offset = r_cursor;
        cur_tok.row    = r_row;
        cur_tok.col    = r_cursor - r_row_start;
        cur_tok.len    = r_eot ? '0 : CNT_W'(1);
        cur_tok.last   = 1'b1;
    end

    // Result selection and next state
    always_comb begin
        o_push.a       = sym_tok;
        o_push.b       = cur_tok;
        o_push.a_valid = 1'b0;
        o_push.b_valid = 1'b0;

        n_in_symbol = r_in_symbol;
        n_cursor    = r_cursor;
        n_row       = r_row;
        n_row_start = r_row_start;
        n_sym_off   = r_sym_off;
        n_sym_row   = r_sym_row;
        n_sym_len   = r_sym_len;
        n_cand      = r_cand;

        if (fire) begin
            if (r_eot) begin
                // Flush, end token, back to reset values
                o_push.a_valid = r_in_symbol;
                o_push.b_valid = 1'b1;
                n_in_symbol = 1'b0;
                n_cursor    = '0;
                n_row       = '0;
                n_row_start = '0;
                n_sym_off   = '0;
                n_sym_row   = '0;
                n_sym_len   = '0;
                n_cand      = '1;
            end else if (is_alnum) begin
                if (r_in_symbol) begin
                    n_cand    = kw_match(r_cand, r_sym_len, r_ch);
                    n_sym_len = (r_sym_len < CNT_MAX) ? r_sym_len + 1'b1 : r_sym_len;
                end else begin
                    n_in_symbol = 1'b1;
                    n_sym_off   = r_cursor;
                    n_sym_row   = r_row;
                    n_cand      = kw_match('1, '0, r_ch);
                    n_sym_len   = CNT_W'(1);
                end
                n_cursor = cur_inc;
            end else begin
                // Flush pending symbol; last moves to it when no byte token
                o_push.a_valid = r_in_symbol;
                o_push.a.last  = is_space;
                o_push.b_valid = !is_space;
                if (r_in_symbol) begin
                    n_in_symbol = 1'b0;
                    n_sym_len   = '0;
                    n_cand      = '1;
                end
                n_cursor = cur_inc;
                if (r_ch == 8'h0a) begin
                    n_row       = (r_row < CNT_MAX) ? r_row + 1'b1 : r_row;
                    n_row_start = cur_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_symbol <= 1'b0;
            r_cursor    <= '0;
            r_row       <= '0;
            r_row_start <= '0;
            r_sym_off   <= '0;
            r_sym_row   <= '0;
            r_sym_len   <= '0;
            r_cand      <= '1;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            r_in_symbol <= n_in_symbol;
            r_cursor    <= n_cursor;
            r_row       <= n_row;
            r_row_start <= n_row_start;
            r_sym_off   <= n_sym_off;
            r_sym_row   <= n_sym_row;
            r_sym_len   <= n_sym_len;
            r_cand      <= n_cand;
        end
    end

    // Input payload register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch  <= i_ch;
            r_eot <= i_end_of_text;
        end
    end

`ifndef SYNTHESIS
    a_push_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.a_valid || o_push.b_valid) |-> fire)
        else $error("result written without a consumed item");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.a_valid && o_push.b_valid) |-> !o_push.a.last)
        else $error("first of two results marked last");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_eot) |=> (r_cursor == '0 && !r_in_symbol && r_row == '0))
        else $error("end item did not clear position state");
`endif

endmodule
